// ===== rtl/core/sdl_pkg.sv =====
// Shared types and constants for the sorted descending list engine.
// Used by sdl_ctrl, sdl_dp and sorted_descending_list_engine; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdl_pkg;

    // Default number of stored values
    localparam int unsigned CAPACITY_DEF = 16;

    // Widths fixed by the request fields
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;

    // Operation codes carried by a request
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT      = 3'd0,
        FN_REMOVE      = 3'd1,
        FN_SEARCH      = 3'd2,
        FN_REMOVE_HEAD = 3'd3,
        FN_CLEAR       = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_LAST,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    // Walk index updates
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_TAIL,
        IDX_INC,
        IDX_DEC
    } idx_cmd_t;

    // Fill count updates
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_cmd_t;

    // Memory address selects: walk index or the entry after it
    typedef enum logic {
        ADDR_IDX,
        ADDR_IDX1
    } addr_sel_t;

    // Memory write data selects
    typedef enum logic {
        WD_VAL,
        WD_RDATA
    } wd_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      ld_op;
        idx_cmd_t  idx_cmd;
        cnt_cmd_t  cnt_cmd;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        addr_sel_t wr_sel;
        wd_sel_t   wd_sel;
        logic      set_status;
        status_t   status_code;
        logic      set_found;
        logic      ld_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  cnt_zero;
        logic  cnt_full;
        logic  idx_zero;
        logic  idx_last;
        logic  less;
        logic  match;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_descending_list_engine.sv =====
// Sorted descending list engine: up to CAPACITY signed values kept largest first.
// Request channel: in_valid/in_ready with func and value. Result channel:
// out_valid/out_ready with status, found, head_value, head_valid and count.
// One request is worked at a time; each returns exactly one result.
// Clear, no-op, full insert and remove or search on an empty store finish without a walk.
// Insert walks from the tail past the stored values smaller than the new one;
// search scans from the head to the match; remove scans, then shifts the later
// values down; remove head shifts the whole store.
// The next request is taken in the cycle after the result is loaded.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the finished next result holds until the register frees.
// Reset empties the store at once (count 0); no clearing pass is needed,
// since entries beyond the count are never read.
// Depends on sdl_pkg, sdl_ctrl and sdl_dp.
`timescale 1ns / 1ps
`default_nettype none

module sorted_descending_list_engine
#(
    parameter int unsigned CAPACITY = sdl_pkg::CAPACITY_DEF,
    localparam int unsigned CW      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [sdl_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [sdl_pkg::VALUE_W-1:0]  value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [sdl_pkg::STATUS_W-1:0]             status,
    output logic                                     found,
    output logic signed [sdl_pkg::VALUE_W-1:0]       head_value,
    output logic                                     head_valid,
    output logic [CW-1:0]                            count
);

    sdl_pkg::ctrl_cmd_t cmd;
    sdl_pkg::dp_stat_t  stat;

    // Sequence the operation
    sdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store, walk and result registers
    sdl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .value      (value),
        .status     (status),
        .found      (found),
        .head_value (head_value),
        .head_valid (head_valid),
        .count      (count)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sdl_ctrl.sv =====
// Controller state machine for the sorted descending list engine.
// Sequences insert, scan and shift walks; depends on sdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdl_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire sdl_pkg::dp_stat_t stat,
    output sdl_pkg::ctrl_cmd_t     cmd
);

    sdl_pkg::state_t state_reg;
    sdl_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == sdl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.idx_cmd     = sdl_pkg::IDX_HOLD;
        cmd.cnt_cmd     = sdl_pkg::CNT_HOLD;
        cmd.rd_sel      = sdl_pkg::ADDR_IDX;
        cmd.wr_sel      = sdl_pkg::ADDR_IDX;
        cmd.wd_sel      = sdl_pkg::WD_VAL;
        cmd.status_code = sdl_pkg::ST_OK;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            sdl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_op  = 1'b1;
                    state_next = sdl_pkg::S_DISPATCH;
                end
            end

            sdl_pkg::S_DISPATCH:
            begin
                unique case (stat.func)
                    sdl_pkg::FN_INSERT:
                    begin
                        if (stat.cnt_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sdl_pkg::ST_FULL;
                            state_next      = sdl_pkg::S_DONE;
                        end
                        else if (stat.cnt_zero)
                        begin
                            cmd.idx_cmd = sdl_pkg::IDX_ZERO;
                            state_next  = sdl_pkg::S_INS_LAST;
                        end
                        else
                        begin
                            cmd.idx_cmd = sdl_pkg::IDX_TAIL;
                            state_next  = sdl_pkg::S_INS_RD;
                        end
                    end
                    sdl_pkg::FN_REMOVE,
                    sdl_pkg::FN_SEARCH:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.set_status  = (stat.func == sdl_pkg::FN_REMOVE);
                            cmd.status_code = sdl_pkg::ST_EMPTY;
                            state_next      = sdl_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.idx_cmd = sdl_pkg::IDX_ZERO;
                            state_next  = sdl_pkg::S_SCAN_RD;
                        end
                    end
                    sdl_pkg::FN_REMOVE_HEAD:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sdl_pkg::ST_EMPTY;
                            state_next      = sdl_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.idx_cmd   = sdl_pkg::IDX_ZERO;
                            cmd.set_found = 1'b1;
                            state_next    = sdl_pkg::S_SH_RD;
                        end
                    end
                    sdl_pkg::FN_CLEAR:
                    begin
                        cmd.cnt_cmd = sdl_pkg::CNT_CLR;
                        state_next  = sdl_pkg::S_DONE;
                    end
                    default:
                    begin
                        state_next = sdl_pkg::S_DONE;
                    end
                endcase
            end

            // Insert walks from the tail, moving smaller values up one slot
            sdl_pkg::S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sdl_pkg::S_INS_CMP;
            end

            sdl_pkg::S_INS_CMP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sdl_pkg::ADDR_IDX1;
                if (stat.less)
                begin
                    cmd.wd_sel = sdl_pkg::WD_RDATA;
                    if (stat.idx_zero)
                    begin
                        state_next = sdl_pkg::S_INS_LAST;
                    end
                    else
                    begin
                        cmd.idx_cmd = sdl_pkg::IDX_DEC;
                        state_next  = sdl_pkg::S_INS_RD;
                    end
                end
                else
                begin
                    cmd.wd_sel  = sdl_pkg::WD_VAL;
                    cmd.cnt_cmd = sdl_pkg::CNT_INC;
                    state_next  = sdl_pkg::S_DONE;
                end
            end

            sdl_pkg::S_INS_LAST:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = sdl_pkg::ADDR_IDX;
                cmd.wd_sel  = sdl_pkg::WD_VAL;
                cmd.cnt_cmd = sdl_pkg::CNT_INC;
                state_next  = sdl_pkg::S_DONE;
            end

            // Scan from the head for the first match
            sdl_pkg::S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sdl_pkg::S_SCAN_CMP;
            end

            sdl_pkg::S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = (stat.func == sdl_pkg::FN_SEARCH) ?
                                    sdl_pkg::S_DONE : sdl_pkg::S_SH_RD;
                end
                else if (stat.idx_last)
                begin
                    cmd.set_status  = (stat.func == sdl_pkg::FN_REMOVE);
                    cmd.status_code = sdl_pkg::ST_NOT_FOUND;
                    state_next      = sdl_pkg::S_DONE;
                end
                else
                begin
                    cmd.idx_cmd = sdl_pkg::IDX_INC;
                    state_next  = sdl_pkg::S_SCAN_RD;
                end
            end

            // Close the gap: move each later value down one slot
            sdl_pkg::S_SH_RD:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_cmd = sdl_pkg::CNT_DEC;
                    state_next  = sdl_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sdl_pkg::ADDR_IDX1;
                    state_next = sdl_pkg::S_SH_WR;
                end
            end

            sdl_pkg::S_SH_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = sdl_pkg::ADDR_IDX;
                cmd.wd_sel  = sdl_pkg::WD_RDATA;
                cmd.idx_cmd = sdl_pkg::IDX_INC;
                state_next  = sdl_pkg::S_SH_RD;
            end

            // Publish the result once the output register is free
            sdl_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.ld_out     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sdl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sdl_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted request is decoded in the next cycle
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == sdl_pkg::S_DISPATCH)
        else $error("accepted request not dispatched");

    // A result is only loaded from the done state
    a_ld_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> state_reg == sdl_pkg::S_DONE)
        else $error("result loaded outside done state");

    // Loading a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/sdl_dp.sv =====
// Datapath for the sorted descending list engine: value memory, walk index,
// fill count, head copy and result registers. Depends on sdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdl_dp
#(
    parameter int unsigned CAPACITY = sdl_pkg::CAPACITY_DEF,
    localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sdl_pkg::ctrl_cmd_t                  cmd,
    output sdl_pkg::dp_stat_t                        stat,
    input  wire logic [sdl_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [sdl_pkg::VALUE_W-1:0]  value,
    output logic [sdl_pkg::STATUS_W-1:0]             status,
    output logic                                     found,
    output logic signed [sdl_pkg::VALUE_W-1:0]       head_value,
    output logic                                     head_valid,
    output logic [CW-1:0]                            count
);

    localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic signed [sdl_pkg::VALUE_W-1:0] mem [CAPACITY];

    sdl_pkg::func_t                     func_reg;
    logic signed [sdl_pkg::VALUE_W-1:0] val_reg;
    logic signed [sdl_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [sdl_pkg::VALUE_W-1:0] head_reg;
    logic [CW-1:0]                      idx_reg;
    logic [CW-1:0]                      idx_next;
    logic [CW-1:0]                      cnt_reg;
    logic [CW-1:0]                      cnt_next;
    logic [CW-1:0]                      idx_plus;
    sdl_pkg::status_t                   status_reg;
    logic                               found_reg;
    sdl_pkg::status_t                   res_status_reg;
    logic                               res_found_reg;
    logic signed [sdl_pkg::VALUE_W-1:0] res_head_reg;
    logic                               res_hvalid_reg;
    logic [CW-1:0]                      res_count_reg;
    logic [AW-1:0]                      rd_addr;
    logic [AW-1:0]                      wr_addr;
    logic signed [sdl_pkg::VALUE_W-1:0] wr_data;

    assign idx_plus = idx_reg + CNT_ONE;

    // Address and data selection
    always_comb
    begin
        rd_addr = (cmd.rd_sel == sdl_pkg::ADDR_IDX1) ? idx_plus[AW-1:0] : idx_reg[AW-1:0];
        wr_addr = (cmd.wr_sel == sdl_pkg::ADDR_IDX1) ? idx_plus[AW-1:0] : idx_reg[AW-1:0];
        wr_data = (cmd.wd_sel == sdl_pkg::WD_RDATA) ? rdata_reg : val_reg;
    end

    // Value memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Walk index and fill count updates
    always_comb
    begin
        unique case (cmd.idx_cmd)
            sdl_pkg::IDX_HOLD: idx_next = idx_reg;
            sdl_pkg::IDX_ZERO: idx_next = '0;
            sdl_pkg::IDX_TAIL: idx_next = cnt_reg - CNT_ONE;
            sdl_pkg::IDX_INC:  idx_next = idx_plus;
            sdl_pkg::IDX_DEC:  idx_next = idx_reg - CNT_ONE;
            default:           idx_next = idx_reg;
        endcase
        unique case (cmd.cnt_cmd)
            sdl_pkg::CNT_HOLD: cnt_next = cnt_reg;
            sdl_pkg::CNT_INC:  cnt_next = cnt_reg + CNT_ONE;
            sdl_pkg::CNT_DEC:  cnt_next = cnt_reg - CNT_ONE;
            sdl_pkg::CNT_CLR:  cnt_next = '0;
            default:           cnt_next = cnt_reg;
        endcase
    end

    // Control state: count, index, operation status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            idx_reg    <= '0;
            status_reg <= sdl_pkg::ST_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.ld_op)
            begin
                status_reg <= sdl_pkg::ST_OK;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.set_status)
                begin
                    status_reg <= cmd.status_code;
                end
                if (cmd.set_found)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Latch request, track the head entry, load the result
    always_ff @(posedge clk)
    begin
        if (cmd.ld_op)
        begin
            func_reg <= sdl_pkg::func_t'(func);
            val_reg  <= value;
        end
        if (cmd.wr_en && wr_addr == '0)
        begin
            head_reg <= wr_data;
        end
        if (cmd.ld_out)
        begin
            res_status_reg <= status_reg;
            res_found_reg  <= found_reg;
            res_head_reg   <= (cnt_reg != '0) ? head_reg : '0;
            res_hvalid_reg <= (cnt_reg != '0);
            res_count_reg  <= cnt_reg;
        end
    end

    // Status toward the controller
    always_comb
    begin
        stat.func     = func_reg;
        stat.cnt_zero = (cnt_reg == '0);
        stat.cnt_full = (cnt_reg >= CNT_MAX);
        stat.idx_zero = (idx_reg == '0);
        stat.idx_last = (idx_plus == cnt_reg);
        stat.less     = (rdata_reg < val_reg);
        stat.match    = (rdata_reg == val_reg);
    end

    assign status     = res_status_reg;
    assign found      = res_found_reg;
    assign head_value = res_head_reg;
    assign head_valid = res_hvalid_reg;
    assign count      = res_count_reg;

    // Fill count never exceeds capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("fill count above capacity");

    // Grow only when room is left, shrink only when not empty
    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_cmd == sdl_pkg::CNT_INC |-> cnt_reg < CNT_MAX)
        else $error("insert into full store");

    a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_cmd == sdl_pkg::CNT_DEC |-> cnt_reg != '0)
        else $error("remove from empty store");

    // Memory writes stay inside the occupied region plus one slot
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> {1'b0, wr_addr} <= {1'b0, cnt_reg})
        else $error("write beyond fill level");

endmodule

`default_nettype wire
